// File: rtl/rva_pkg.sv
// ----------------------------------------------------------------------------
// rva_pkg
// shared widths, fixed-point constants, cell data types and the atan table
// for the axis-angle vector rotation pipeline
// ----------------------------------------------------------------------------
package rva_pkg;

  localparam int COMP_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 14;
  localparam int ANGLE_BITS        = 16;
  localparam int ATAN_LEN          = 24;

  // cordic datapath, q30 angles and coordinates
  localparam int CW = 36;

  // integer square root chain
  localparam int SW         = 61;
  localparam int SQRT_STEPS = 30;
  localparam int SQRT_TOP   = 58;

  // reciprocal divider chain
  localparam int DW        = 59;
  localparam int RW        = 30;
  localparam int QW        = 29;
  localparam int DIV_STEPS = 29;

  localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] NEG_PI_Q30  = -36'sd3373259426;
  localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] NEG_HALF_PI = -36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_K    = 36'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [RW-1:0] dvs;
    logic [QW-1:0] quo;
  } div_t;

  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] a;
    case (idx)
      0:  a = 36'sd843314856;
      1:  a = 36'sd497837829;
      2:  a = 36'sd263043836;
      3:  a = 36'sd133525158;
      4:  a = 36'sd67021686;
      5:  a = 36'sd33543515;
      6:  a = 36'sd16775850;
      7:  a = 36'sd8388437;
      8:  a = 36'sd4194282;
      9:  a = 36'sd2097149;
      10: a = 36'sd1048575;
      11: a = 36'sd524287;
      12: a = 36'sd262143;
      13: a = 36'sd131071;
      14: a = 36'sd65535;
      15: a = 36'sd32767;
      16: a = 36'sd16383;
      17: a = 36'sd8191;
      18: a = 36'sd4095;
      19: a = 36'sd2047;
      20: a = 36'sd1023;
      21: a = 36'sd511;
      22: a = 36'sd255;
      23: a = 36'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/rva_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rva_sqrt_cell
// one step of the digit-by-digit integer square root
// ----------------------------------------------------------------------------
module rva_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  rva_pkg::sqrt_t        din,
  output rva_pkg::sqrt_t        dout
);

  localparam logic [rva_pkg::SW-1:0] ONE =
    rva_pkg::SW'(1) << (rva_pkg::SQRT_TOP - 2 * IDX);

  logic [rva_pkg::SW-1:0] trial;

  assign trial = din.res + ONE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.rem >= trial) begin
        dout.rem <= din.rem - trial;
        dout.res <= (din.res >> 1) + ONE;
      end else begin
        dout.rem <= din.rem;
        dout.res <= din.res >> 1;
      end
    end
  end

endmodule

// File: rtl/rva_cordic_cell.sv
// ----------------------------------------------------------------------------
// rva_cordic_cell
// one rotation-mode cordic micro-rotation
// ----------------------------------------------------------------------------
module rva_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  rva_pkg::cordic_t      din,
  output rva_pkg::cordic_t      dout
);

  localparam logic signed [rva_pkg::CW-1:0] ATAN = rva_pkg::atan_q30(IDX);

  logic signed [rva_pkg::CW-1:0] dx;
  logic signed [rva_pkg::CW-1:0] dy;

  assign dx = din.y >>> IDX;
  assign dy = din.x >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      if (din.z >= 0) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - ATAN;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + ATAN;
      end
    end
  end

endmodule

// File: rtl/rva_div_cell.sv
// ----------------------------------------------------------------------------
// rva_div_cell
// one quotient bit of the restoring reciprocal divider
// ----------------------------------------------------------------------------
module rva_div_cell #(
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  rva_pkg::div_t         din,
  output rva_pkg::div_t         dout
);

  logic [rva_pkg::DW-1:0] dsh;

  assign dsh = rva_pkg::DW'(din.dvs) << BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      dout.dvs <= din.dvs;
      if (din.rem >= dsh) begin
        dout.rem <= din.rem - dsh;
        dout.quo <= din.quo | (rva_pkg::QW'(1) << BIT);
      end else begin
        dout.rem <= din.rem;
        dout.quo <= din.quo;
      end
    end
  end

endmodule

// File: rtl/rotate_vector_about_axis.sv
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// rotates a q7.8 vector about an arbitrary axis by a q3.12 angle
// (rodrigues matrix), with axis normalization, cordic sin/cos and saturation
// ----------------------------------------------------------------------------
//  channel | handshake            | beat contents
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | vec_x/y/z, axis_x/y/z, turn_angle
//  out     | out_valid / out_ready| out_x/y/z, axis_was_zero, clipped
//
//  one beat per clock in and out while the pipeline is not stalled; the
//  30-cell square root chain and the 29-cell divider chain run in series
//  cordic cells run beside the square root cells
//  a two-entry output buffer takes results; the pipeline stalls only when
//  both entries are full and out_ready is low
//  rst clears the valid bits and the output buffer
// ----------------------------------------------------------------------------
module rotate_vector_about_axis #(
  parameter int COMP_WIDTH    = rva_pkg::COMP_WIDTH_DEF,
  parameter int CORDIC_STAGES = rva_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COMP_WIDTH-1:0]         vec_x,
  input  logic signed [COMP_WIDTH-1:0]         vec_y,
  input  logic signed [COMP_WIDTH-1:0]         vec_z,
  input  logic signed [COMP_WIDTH-1:0]         axis_x,
  input  logic signed [COMP_WIDTH-1:0]         axis_y,
  input  logic signed [COMP_WIDTH-1:0]         axis_z,
  input  logic signed [rva_pkg::ANGLE_BITS-1:0] turn_angle,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [COMP_WIDTH-1:0]         out_x,
  output logic signed [COMP_WIDTH-1:0]         out_y,
  output logic signed [COMP_WIDTH-1:0]         out_z,
  output logic                                 axis_was_zero,
  output logic                                 clipped
);

  localparam int W   = COMP_WIDTH;
  localparam int PW  = $clog2(W);
  localparam int CW  = rva_pkg::CW;
  localparam int NC  = (CORDIC_STAGES < rva_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                          : rva_pkg::ATAN_LEN;
  localparam int NSQ = rva_pkg::SQRT_STEPS;
  localparam int NDV = rva_pkg::DIV_STEPS;
  localparam int MW  = 36;
  localparam int PRW = MW + W;
  localparam int AW  = PRW + 2;
  localparam int BW  = 3 * W + 2;

  localparam logic signed [AW-1:0] OHI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] OLO = -OHI - AW'(1);

  typedef struct packed {
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [W-1:0] vz;
    logic [2:0]          sgn;
    logic [14:0]         m0;
    logic [14:0]         m1;
    logic [14:0]         m2;
    logic                zero;
    logic                neg;
    logic signed [16:0]  c;
    logic signed [16:0]  s;
  } side_t;

  logic adv;
  logic [1:0] ocnt;
  logic [1:0] ocnt_next;

  assign adv      = (ocnt != 2'd2) || out_ready;
  assign in_ready = adv;

  // stage 1: magnitudes, signs, angle reduced by whole turns
  logic [W-1:0]           mag_in [3];
  logic signed [CW-1:0]   zr;
  side_t                  sd1_next;
  logic                   v1;
  side_t                  sd1;
  logic [W-1:0]           mag1 [3];
  logic signed [CW-1:0]   z1;

  always_comb begin
    mag_in[0] = axis_x[W-1] ? (~axis_x + W'(1)) : axis_x;
    mag_in[1] = axis_y[W-1] ? (~axis_y + W'(1)) : axis_y;
    mag_in[2] = axis_z[W-1] ? (~axis_z + W'(1)) : axis_z;
    zr = {{(CW-rva_pkg::ANGLE_BITS-18){turn_angle[rva_pkg::ANGLE_BITS-1]}},
          turn_angle, 18'b0};
    for (int i = 0; i < 3; i++) begin
      if (zr > rva_pkg::PI_Q30) begin
        zr = zr - rva_pkg::TWO_PI_Q30;
      end else if (zr < rva_pkg::NEG_PI_Q30) begin
        zr = zr + rva_pkg::TWO_PI_Q30;
      end
    end
    sd1_next      = '0;
    sd1_next.vx   = vec_x;
    sd1_next.vy   = vec_y;
    sd1_next.vz   = vec_z;
    sd1_next.sgn  = {axis_z[W-1], axis_y[W-1], axis_x[W-1]};
    sd1_next.zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      sd1  <= sd1_next;
      mag1 <= mag_in;
      z1   <= zr;
    end
  end

  // stage 2: axis scaled so the largest magnitude sits in [2^14, 2^15),
  // angle folded into +-pi/2
  logic [W-1:0]           mor;
  logic [PW-1:0]          msb;
  logic [14:0]            nm [3];
  logic [W+14:0]          ext;
  logic signed [CW-1:0]   zf;
  logic                   nf;
  side_t                  sd2_next;
  logic                   v2;
  side_t                  sd2;
  logic signed [CW-1:0]   z2;

  always_comb begin
    mor = mag1[0] | mag1[1] | mag1[2];
    msb = '0;
    for (int i = 0; i < W; i++) begin
      if (mor[i]) msb = PW'(i);
    end
    ext = '0;
    for (int i = 0; i < 3; i++) begin
      ext = {15'b0, mag1[i]};
      if (int'(msb) >= 14) begin
        nm[i] = 15'(ext >> (int'(msb) - 14));
      end else begin
        nm[i] = 15'(ext << (14 - int'(msb)));
      end
    end
    zf = z1;
    nf = 1'b0;
    if (z1 > rva_pkg::HALF_PI_Q30) begin
      zf = z1 - rva_pkg::PI_Q30;
      nf = 1'b1;
    end else if (z1 < rva_pkg::NEG_HALF_PI) begin
      zf = z1 + rva_pkg::PI_Q30;
      nf = 1'b1;
    end
    sd2_next     = sd1;
    sd2_next.m0  = nm[0];
    sd2_next.m1  = nm[1];
    sd2_next.m2  = nm[2];
    sd2_next.neg = nf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      sd2 <= sd2_next;
      z2  <= zf;
    end
  end

  // stage 3: squares
  logic                   v3;
  side_t                  sd3;
  logic signed [CW-1:0]   z3;
  logic [29:0]            sq3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      sd3    <= sd2;
      z3     <= z2;
      sq3[0] <= 30'(sd2.m0) * 30'(sd2.m0);
      sq3[1] <= 30'(sd2.m1) * 30'(sd2.m1);
      sq3[2] <= 30'(sd2.m2) * 30'(sd2.m2);
    end
  end

  // square root chain with cordic cells alongside
  logic                   sv [0:NSQ];
  side_t                  ssd [0:NSQ];
  rva_pkg::sqrt_t         sq [0:NSQ];
  rva_pkg::cordic_t       cd [0:NSQ];
  logic [31:0]            l2;

  assign l2 = 32'(sq3[0]) + 32'(sq3[1]) + 32'(sq3[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v3;
    end
    if (adv) begin
      ssd[0]    <= sd3;
      sq[0].rem <= rva_pkg::SW'(l2) << 28;
      sq[0].res <= '0;
      cd[0].x   <= rva_pkg::CORDIC_K;
      cd[0].y   <= '0;
      cd[0].z   <= z3;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    rva_sqrt_cell #(.IDX(k)) u_sqrt (
      .clk  (clk),
      .en   (adv),
      .din  (sq[k]),
      .dout (sq[k+1])
    );
    if (k < NC) begin : g_cordic
      rva_cordic_cell #(.IDX(k)) u_cordic (
        .clk  (clk),
        .en   (adv),
        .din  (cd[k]),
        .dout (cd[k+1])
      );
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (adv) cd[k+1] <= cd[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
      if (adv) ssd[k+1] <= ssd[k];
    end
  end

  // stage 5: cos/sin rounding, divider setup
  logic [rva_pkg::RW-1:0] rroot;
  logic signed [CW-1:0]   cx;
  logic signed [CW-1:0]   cy;
  logic signed [CW-1:0]   cr;
  logic signed [CW-1:0]   sr;
  side_t                  dsd_next;
  logic                   dv [0:NDV];
  side_t                  dsd [0:NDV];
  rva_pkg::div_t          dd [0:NDV];

  always_comb begin
    rroot = sq[NSQ].res[rva_pkg::RW-1:0];
    cx = ssd[NSQ].neg ? -cd[NSQ].x : cd[NSQ].x;
    cy = ssd[NSQ].neg ? -cd[NSQ].y : cd[NSQ].y;
    cr = (cx + CW'(32768)) >>> 16;
    sr = (cy + CW'(32768)) >>> 16;
    dsd_next   = ssd[NSQ];
    dsd_next.c = cr[16:0];
    dsd_next.s = sr[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[NSQ];
    end
    if (adv) begin
      dsd[0]     <= dsd_next;
      dd[0].rem  <= (rva_pkg::DW'(1) << 56) + rva_pkg::DW'(rroot >> 1);
      dd[0].dvs  <= rroot;
      dd[0].quo  <= '0;
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_div
    rva_div_cell #(.BIT(NDV - 1 - j)) u_div (
      .clk  (clk),
      .en   (adv),
      .din  (dd[j]),
      .dout (dd[j+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= dv[j];
      end
      if (adv) dsd[j+1] <= dsd[j];
    end
  end

  // stage 6: unit axis
  logic [43:0]            up [3];
  logic [15:0]            um [3];
  logic signed [16:0]     un [3];
  logic                   v6;
  side_t                  sd6;
  logic signed [16:0]     u6 [3];

  always_comb begin
    up[0] = 44'(dsd[NDV].m0) * 44'(dd[NDV].quo);
    up[1] = 44'(dsd[NDV].m1) * 44'(dd[NDV].quo);
    up[2] = 44'(dsd[NDV].m2) * 44'(dd[NDV].quo);
    for (int i = 0; i < 3; i++) begin
      um[i] = 16'((up[i] + 44'd134217728) >> 28);
      un[i] = dsd[NDV].sgn[i] ? -$signed({1'b0, um[i]}) : $signed({1'b0, um[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= dv[NDV];
    end
    if (adv) begin
      sd6 <= dsd[NDV];
      u6  <= un;
    end
  end

  // stage 7: outer products, skew terms, 1 - cos
  logic signed [33:0]     pp [6];
  logic signed [33:0]     pr [6];
  logic signed [33:0]     ww [3];
  logic                   v7;
  side_t                  sd7;
  logic signed [16:0]     p7 [6];
  logic signed [33:0]     w7 [3];
  logic signed [17:0]     t7;

  always_comb begin
    pp[0] = u6[0] * u6[0];
    pp[1] = u6[1] * u6[1];
    pp[2] = u6[2] * u6[2];
    pp[3] = u6[0] * u6[1];
    pp[4] = u6[0] * u6[2];
    pp[5] = u6[1] * u6[2];
    for (int i = 0; i < 6; i++) begin
      pr[i] = (pp[i] + 34'sd8192) >>> 14;
    end
    for (int i = 0; i < 3; i++) begin
      ww[i] = u6[i] * sd6.s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      sd7 <= sd6;
      for (int i = 0; i < 6; i++) p7[i] <= pr[i][16:0];
      w7  <= ww;
      t7  <= 18'sd16384 - 18'(sd6.c);
    end
  end

  // stage 8: scaled outer products
  logic                   v8;
  side_t                  sd8;
  logic signed [34:0]     q8 [6];
  logic signed [33:0]     w8 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
    if (adv) begin
      sd8 <= sd7;
      w8  <= w7;
      for (int i = 0; i < 6; i++) q8[i] <= p7[i] * t7;
    end
  end

  // stage 9: rotation matrix
  logic signed [MW-1:0]   cc;
  logic signed [MW-1:0]   mm [9];
  logic                   v9;
  side_t                  sd9;
  logic signed [MW-1:0]   m9 [9];

  always_comb begin
    cc    = MW'(sd8.c) <<< 14;
    mm[0] = cc + MW'(q8[0]);
    mm[1] = MW'(q8[3]) - MW'(w8[2]);
    mm[2] = MW'(q8[4]) + MW'(w8[1]);
    mm[3] = MW'(q8[3]) + MW'(w8[2]);
    mm[4] = cc + MW'(q8[1]);
    mm[5] = MW'(q8[5]) - MW'(w8[0]);
    mm[6] = MW'(q8[4]) - MW'(w8[1]);
    mm[7] = MW'(q8[5]) + MW'(w8[0]);
    mm[8] = cc + MW'(q8[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
    if (adv) begin
      sd9 <= sd8;
      m9  <= mm;
    end
  end

  // stage 10: matrix times vector
  logic                   v10;
  side_t                  sd10;
  logic signed [PRW-1:0]  pv10 [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= v9;
    end
    if (adv) begin
      sd10 <= sd9;
      for (int r = 0; r < 3; r++) begin
        pv10[3*r]   <= m9[3*r]   * sd9.vx;
        pv10[3*r+1] <= m9[3*r+1] * sd9.vy;
        pv10[3*r+2] <= m9[3*r+2] * sd9.vz;
      end
    end
  end

  // row sums, rounding, saturation
  logic signed [AW-1:0]   acc [3];
  logic signed [AW-1:0]   ro [3];
  logic signed [W-1:0]    oc [3];
  logic [2:0]             oclip;
  logic [BW-1:0]          beat;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AW'(pv10[3*r]) + AW'(pv10[3*r+1]) + AW'(pv10[3*r+2]);
      ro[r]  = (acc[r] + AW'(134217728)) >>> 28;
      oclip[r] = 1'b0;
      if (ro[r] > OHI) begin
        oc[r] = OHI[W-1:0];
        oclip[r] = 1'b1;
      end else if (ro[r] < OLO) begin
        oc[r] = OLO[W-1:0];
        oclip[r] = 1'b1;
      end else begin
        oc[r] = ro[r][W-1:0];
      end
    end
    if (sd10.zero) begin
      beat = {sd10.vx, sd10.vy, sd10.vz, 1'b1, 1'b0};
    end else begin
      beat = {oc[0], oc[1], oc[2], 1'b0, |oclip};
    end
  end

  // two-entry output buffer
  logic          push;
  logic          pop;
  logic [BW-1:0] head;
  logic [BW-1:0] skid;

  assign push      = adv && v10;
  assign pop       = out_valid && out_ready;
  assign out_valid = (ocnt != 2'd0);
  assign ocnt_next = ocnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt_next;
    end
    if (pop && (ocnt == 2'd2)) begin
      head <= skid;
    end else if (push && ((ocnt == 2'd0) || ((ocnt == 2'd1) && pop))) begin
      head <= beat;
    end
    if (push && (((ocnt == 2'd1) && !pop) || (ocnt == 2'd2))) begin
      skid <= beat;
    end
  end

  assign out_x         = head[BW-1 -: W];
  assign out_y         = head[BW-1-W -: W];
  assign out_z         = head[BW-1-2*W -: W];
  assign axis_was_zero = head[1];
  assign clipped       = head[0];

endmodule
